>>> rtl/id3tf_pkg.sv
// ----------------------------------------------------------------------------
// id3tf_pkg
// shared types and constants of the id3 text frame to utf-8 converter
// ----------------------------------------------------------------------------
package id3tf_pkg;

  localparam int MAX_OUTPUT_DEFAULT = 1023;
  localparam int CAP_W              = 10;
  localparam int CAP_FIELD_MAX      = 1023;

  // encoding of the frame, as held after the selector byte
  localparam logic [1:0] MODE_LATIN1 = 2'd0;
  localparam logic [1:0] MODE_UTF16  = 2'd1;
  localparam logic [1:0] MODE_UTF8   = 2'd3;

  // selector byte values for latin-1 and utf-8; any other value picks utf-16
  localparam logic [7:0] SEL_LATIN1 = 8'h00;
  localparam logic [7:0] SEL_UTF8   = 8'h03;

  localparam logic [15:0] BOM_LE = 16'hFEFF;
  localparam logic [15:0] BOM_BE = 16'hFFFE;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic             is_first;
    logic             is_last;
    logic [CAP_W-1:0] out_capacity;
  } item_t;

  typedef struct packed {
    logic [1:0]       mode;
    logic [CAP_W-1:0] written;
    logic [CAP_W-1:0] capacity;
    logic             stopped;
    logic [7:0]       low_byte;
    logic             pair_phase;
    logic             first_pending;
  } state_t;

  // results of one input byte: up to three text bytes, then an end marker
  typedef struct packed {
    logic [7:0]       byte0;
    logic [7:0]       byte1;
    logic [7:0]       byte2;
    logic [1:0]       nbytes;
    logic             has_end;
    logic [CAP_W-1:0] base;
  } grp_t;

endpackage

>>> rtl/id3_text_frame_to_utf8_unit.sv
// ----------------------------------------------------------------------------
// id3_text_frame_to_utf8_unit
// id3v2 text frame payload (latin-1, utf-16, utf-8) to utf-8 byte stream
// ----------------------------------------------------------------------------
// feed the payload of one text frame a byte per transfer, the encoding selector
// first with is_first set and the final byte with is_last set. each byte gives
// zero to three utf-8 text bytes, and the final byte adds an end marker
// carrying the string length. a byte that yields no result bypasses the result
// register; a byte that yields k results (1 to 4) holds the single output port
// until all k are taken, one transfer at a time. a new byte is taken every
// cycle while the result register is free or draining its last result.
// out_capacity is sampled with the selector and clamped to MAX_OUTPUT (at most
// 1023); no text byte is ever emitted past it.
module id3_text_frame_to_utf8_unit #(
  parameter int MAX_OUTPUT = id3tf_pkg::MAX_OUTPUT_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  data_byte,
  input  logic                        is_first,
  input  logic                        is_last,
  input  logic [id3tf_pkg::CAP_W-1:0] out_capacity,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [7:0]                  out_byte,
  output logic                        byte_valid,
  output logic                        end_of_text,
  output logic [id3tf_pkg::CAP_W-1:0] text_length
);
  import id3tf_pkg::*;

  item_t  in_q;
  logic   in_full;
  state_t st;
  state_t st_next;
  grp_t   grp;
  logic   grp_empty;
  logic   grp_ready;
  logic   advance;

  // input register: one payload byte waiting for the decoder
  assign grp_empty = (grp.nbytes == 2'd0) && !grp.has_end;
  assign advance   = in_full && (grp_empty || grp_ready);
  assign in_ready  = !in_full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q.data_byte    <= data_byte;
      in_q.is_first     <= is_first;
      in_q.is_last      <= is_last;
      in_q.out_capacity <= out_capacity;
    end
  end

  // frame state moves only when the byte leaves the input register
  id3tf_state u_state (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .st_next (st_next),
    .st      (st)
  );

  id3tf_decode #(
    .MAX_OUTPUT (MAX_OUTPUT)
  ) u_decode (
    .item    (in_q),
    .st      (st),
    .st_next (st_next),
    .grp     (grp)
  );

  // result register and serializer; bytes that give nothing bypass it
  id3tf_emit u_emit (
    .clk         (clk),
    .rst         (rst),
    .grp_valid   (in_full && !grp_empty),
    .grp         (grp),
    .grp_ready   (grp_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_byte    (out_byte),
    .byte_valid  (byte_valid),
    .end_of_text (end_of_text),
    .text_length (text_length)
  );

`ifndef NO_ASSERTIONS
  // a held low byte only exists on the utf-16 path
  a_pair_mode : assert property (@(posedge clk) disable iff (rst)
    st.pair_phase |-> st.mode == MODE_UTF16)
    else $error("pair phase set outside utf-16 mode");

  // the count of written bytes never passes the frame capacity
  a_count_cap : assert property (@(posedge clk) disable iff (rst)
    st.written <= st.capacity)
    else $error("written count above capacity");

  // the state holds while a byte waits on a busy result register
  a_state_hold : assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> $stable(st))
    else $error("frame state moved without consuming a byte");
`endif

endmodule

>>> rtl/id3tf_decode.sv
// ----------------------------------------------------------------------------
// id3tf_decode
// next-state and result-group logic for one registered payload byte
// ----------------------------------------------------------------------------
module id3tf_decode #(
  parameter int MAX_OUTPUT = id3tf_pkg::MAX_OUTPUT_DEFAULT
) (
  input  id3tf_pkg::item_t  item,
  input  id3tf_pkg::state_t st,
  output id3tf_pkg::state_t st_next,
  output id3tf_pkg::grp_t   grp
);
  import id3tf_pkg::*;

  localparam int               CapSat   = (MAX_OUTPUT > CAP_FIELD_MAX) ? CAP_FIELD_MAX
                                                                      : MAX_OUTPUT;
  localparam logic [CAP_W-1:0] CapLimit = CAP_W'(CapSat);

  logic [15:0]      cp;
  logic [1:0]       need;
  logic             fits;
  logic             full;
  logic             bom;
  logic [CAP_W-1:0] cap_sat;
  logic [1:0]       sel_mode;
  logic [7:0]       e0, e1, e2;

  assign cp = (st.mode == MODE_UTF16) ? {item.data_byte, st.low_byte}
                                      : {8'h00, item.data_byte};

  always_comb begin
    priority if (st.mode == MODE_UTF8 || cp < 16'h0080) need = 2'd1;
    else if (cp < 16'h0800)                             need = 2'd2;
    else                                                need = 2'd3;
  end

  assign fits    = ({1'b0, st.written} + {{(CAP_W-1){1'b0}}, need}) <= {1'b0, st.capacity};
  assign full    = st.written >= st.capacity;
  assign bom     = (cp == BOM_LE) || (cp == BOM_BE);
  assign cap_sat = (item.out_capacity > CapLimit) ? CapLimit : item.out_capacity;

  always_comb begin
    priority if (item.data_byte == SEL_UTF8) sel_mode = MODE_UTF8;
    else if (item.data_byte == SEL_LATIN1)   sel_mode = MODE_LATIN1;
    else                                     sel_mode = MODE_UTF16;
  end

  // utf-8 byte images of the unit
  always_comb begin
    e1 = 8'h80 | {2'b00, cp[5:0]};
    e2 = 8'h80 | {2'b00, cp[5:0]};
    unique case (need)
      2'd2: begin
        e0 = 8'hC0 | {3'b000, cp[10:6]};
      end
      2'd3: begin
        e0 = 8'hE0 | {4'h0, cp[15:12]};
        e1 = 8'h80 | {2'b00, cp[11:6]};
      end
      default: begin
        e0 = cp[7:0];
      end
    endcase
  end

  always_comb begin
    st_next     = st;
    grp         = '0;
    grp.base    = item.is_first ? '0 : st.written;
    grp.byte0   = e0;
    grp.byte1   = e1;
    grp.byte2   = e2;
    if (item.is_first) begin
      st_next.mode          = sel_mode;
      st_next.capacity      = cap_sat;
      st_next.written       = '0;
      st_next.stopped       = 1'b0;
      st_next.low_byte      = '0;
      st_next.pair_phase    = 1'b0;
      st_next.first_pending = 1'b1;
    end else if (!st.stopped) begin
      if (st.mode == MODE_UTF16 && !st.pair_phase) begin
        st_next.low_byte   = item.data_byte;
        st_next.pair_phase = 1'b1;
      end else begin
        st_next.pair_phase    = 1'b0;
        st_next.first_pending = (st.mode == MODE_UTF16) ? 1'b0 : st.first_pending;
        if (st.mode == MODE_UTF16 && st.first_pending && bom) begin
          // leading byte-order mark, dropped
        end else if (full || (st.mode == MODE_UTF16 && cp == 16'h0000)) begin
          st_next.stopped = 1'b1;
        end else if (!fits) begin
          st_next.stopped = 1'b1;
        end else begin
          grp.nbytes      = need;
          st_next.written = st.written + CAP_W'(need);
        end
      end
    end
    if (item.is_last) begin
      grp.has_end     = 1'b1;
      st_next.stopped = 1'b1;
    end
  end

endmodule

>>> rtl/id3tf_emit.sv
// ----------------------------------------------------------------------------
// id3tf_emit
// result register that hands out one group's results one transfer at a time
// ----------------------------------------------------------------------------
module id3tf_emit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               grp_valid,
  input  id3tf_pkg::grp_t                    grp,
  output logic                               grp_ready,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_byte,
  output logic                               byte_valid,
  output logic                               end_of_text,
  output logic [id3tf_pkg::CAP_W-1:0]        text_length
);
  import id3tf_pkg::*;

  grp_t       held;
  logic       loaded;
  logic [1:0] idx;
  logic [2:0] total;
  logic       last_one;
  logic       is_byte;
  logic [2:0] offset;

  assign total     = {1'b0, held.nbytes} + {2'b00, held.has_end};
  assign last_one  = ({1'b0, idx} + 3'd1) == total;
  assign grp_ready = !loaded || (out_ready && last_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded <= 1'b0;
      idx    <= '0;
    end else if (grp_valid && grp_ready) begin
      loaded <= 1'b1;
      idx    <= '0;
    end else if (loaded && out_ready) begin
      if (last_one) begin
        loaded <= 1'b0;
      end
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (grp_valid && grp_ready) begin
      held <= grp;
    end
  end

  assign is_byte = idx < held.nbytes;

  always_comb begin
    unique case (idx)
      2'd0:    out_byte = held.byte0;
      2'd1:    out_byte = held.byte1;
      2'd2:    out_byte = held.byte2;
      default: out_byte = 8'h00;
    endcase
    if (!is_byte) begin
      out_byte = 8'h00;
    end
  end

  assign offset      = is_byte ? ({1'b0, idx} + 3'd1) : {1'b0, held.nbytes};
  assign out_valid   = loaded;
  assign byte_valid  = is_byte;
  assign end_of_text = !is_byte;
  assign text_length = held.base + CAP_W'(offset);

endmodule

>>> rtl/id3tf_text_frame_top_dummy_placeholder.sv
// ----------------------------------------------------------------------------
// id3tf_state
// frame state register, advanced once per consumed payload byte
// ----------------------------------------------------------------------------
module id3tf_state (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  id3tf_pkg::state_t st_next,
  output id3tf_pkg::state_t st
);
  import id3tf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{mode:          MODE_LATIN1,
              written:       '0,
              capacity:      '0,
              stopped:       1'b0,
              low_byte:      '0,
              pair_phase:    1'b0,
              first_pending: 1'b1};
    end else if (advance) begin
      st <= st_next;
    end
  end

endmodule
